// ===== rtl/line_edge_steering_pid_core_defines.svh =====
// ----------------------------------------------------------------------------
// line_edge_steering_pid_core_defines
// Assertion macros shared by the line edge steering PID core.
// ----------------------------------------------------------------------------
`ifndef LINE_EDGE_STEERING_PID_CORE_DEFINES_SVH
`define LINE_EDGE_STEERING_PID_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// checked outside reset
`define LESP_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lesp assertion failed");
// checked on every edge, reset included
`define LESP_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("lesp assertion failed");
`else
`define LESP_ASSERT(label, prop)
`define LESP_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ===== rtl/lesp_pkg.sv =====
// ----------------------------------------------------------------------------
// lesp_pkg
// Types and constants of the line edge steering PID core.
// ----------------------------------------------------------------------------
package lesp_pkg;

    parameter int LINE_PIXELS = 128;
    parameter int IDX_W       = $clog2(LINE_PIXELS);
    parameter int POS_W       = $clog2(LINE_PIXELS + 1);
    parameter logic [IDX_W-1:0] LAST_IDX   = IDX_W'(LINE_PIXELS - 1);
    parameter logic [POS_W-1:0] LINE_COUNT = POS_W'(LINE_PIXELS);
    parameter logic [POS_W-1:0] LAST_POS   = POS_W'(LINE_PIXELS - 1);

    parameter int EDGE_W  = 7;
    parameter int DUTY_W  = 16;
    parameter int SPEED_W = 16;
    parameter int ERR_W   = 8;
    parameter int CFG_IDX_W = 3;
    parameter int CFG_DATA_W = 16;

    typedef logic [EDGE_W-1:0]         edge_t;
    typedef logic [DUTY_W-1:0]         duty_t;
    typedef logic [SPEED_W-1:0]        speed_t;
    typedef logic signed [ERR_W-1:0]   err_t;
    typedef logic [IDX_W-1:0]          idx_t;
    typedef logic [POS_W-1:0]          pos_t;

    // speed: 8 fraction bits
    parameter speed_t SPEED_TARGET = 16'd7680;
    parameter speed_t SPEED_TURN   = 16'd6400;
    parameter logic [22:0] SPEED_STEP_GAIN = 23'd655;
    parameter logic [22:0] SPEED_ROUND     = 23'd32768;

    parameter duty_t DUTY_UPPER_RST  = 16'd6554;
    parameter duty_t DUTY_LOWER_RST  = 16'd3277;
    parameter edge_t LEFT_TOL_RST    = 7'd40;
    parameter edge_t RIGHT_TOL_RST   = 7'd88;
    parameter duty_t GAIN_P_RST      = 16'd313;
    parameter duty_t GAIN_I_RST      = 16'd0;
    parameter duty_t GAIN_D_RST      = 16'd0;
    parameter duty_t CENTRE_DUTY_RST = 16'd4751;

    typedef enum logic [1:0] {
        DIR_STRAIGHT = 2'd0,
        DIR_RIGHT    = 2'd1,
        DIR_LEFT     = 2'd2
    } dir_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DUTY_UPPER  = 3'd0,
        CFG_DUTY_LOWER  = 3'd1,
        CFG_LEFT_TOL    = 3'd2,
        CFG_RIGHT_TOL   = 3'd3,
        CFG_GAIN_P      = 3'd4,
        CFG_GAIN_I      = 3'd5,
        CFG_GAIN_D      = 3'd6,
        CFG_CENTRE_DUTY = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        duty_t duty_upper;
        duty_t duty_lower;
        edge_t left_tol;
        edge_t right_tol;
        duty_t gain_p;
        duty_t gain_i;
        duty_t gain_d;
        duty_t centre_duty;
    } cfg_t;

    typedef struct packed {
        edge_t left_edge;
        edge_t right_edge;
    } edges_t;

    typedef struct packed {
        err_t   steer_error;
        edge_t  right_edge;
        edge_t  left_edge;
        speed_t drive_speed;
        duty_t  servo_duty;
        dir_t   direction;
    } res_t;

endpackage

// ===== rtl/line_edge_steering_pid_core.sv =====
// ----------------------------------------------------------------------------
// line_edge_steering_pid_core
// Line camera edge finder with incremental PID steering and speed ramp.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one binarized pixel per transfer in s_tdata[0], left to
//   right; s_tlast high on the last pixel of a line. Pixels past the line
//   length are ignored, a short line reads missing pixels as zero.
//   Master stream: one result transfer per line, none for other pixels.
//   Configuration: write cfg_wdata to register cfg_index while cfg_we is
//   high; write only while no line result is pending.
//   Throughput: one pixel per clock; a line may be a single pixel.
//   Result path: the s_tlast pixel loads the input register at its transfer
//   edge; the result register and m_tvalid load when that pixel advances.
//   Reset clears line tracking, error history, duty to centre and speed to
//   25.0; registers take their defaults. No clearing pass.
//   Stall: a waiting result holds in the output register; pixels keep
//   flowing until an end-of-line pixel reaches the input register, which
//   then holds and deasserts s_tready until the result is taken.
// ----------------------------------------------------------------------------
`include "line_edge_steering_pid_core_defines.svh"

module line_edge_steering_pid_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [0] pixel
    input  logic                                s_tlast,   // line_end
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [1:0] direction, [17:2] servo_duty, [33:18] drive_speed,
    // [40:34] left_edge, [47:41] right_edge, [55:48] steer_error
    output logic [55:0]                         m_tdata,
    input  logic                                cfg_we,
    input  logic [lesp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lesp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    logic             a_valid_reg;
    logic             a_valid_next;
    logic             a_pixel_reg;
    logic             a_last_reg;
    logic             a_advance;
    logic             end_step;
    logic             s_accept;

    logic             out_valid_reg;
    logic             out_valid_next;
    lesp_pkg::res_t   out_res_reg;

    lesp_pkg::cfg_t   cfg;
    lesp_pkg::edges_t edges;
    lesp_pkg::res_t   res;

    assign a_advance = a_valid_reg && (!a_last_reg || !out_valid_reg || m_tready);
    assign end_step  = a_advance && a_last_reg;
    assign s_tready  = !a_valid_reg || a_advance;
    assign s_accept  = s_tvalid && s_tready;

    assign a_valid_next   = s_accept ? 1'b1 : (a_advance ? 1'b0 : a_valid_reg);
    assign out_valid_next = end_step ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            a_pixel_reg <= s_tdata[0];
            a_last_reg  <= s_tlast;
        end
        if (end_step)
        begin
            out_res_reg <= res;
        end
    end

    lesp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    lesp_edge u_edge (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (a_advance),
        .pixel    (a_pixel_reg),
        .line_end (a_last_reg),
        .edges    (edges)
    );

    lesp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .end_step (end_step),
        .edges    (edges),
        .cfg      (cfg),
        .res      (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg;

    `LESP_ASSERT(a_line_end_gives_result, end_step |=> m_tvalid)
    `LESP_ASSERT_ALWAYS(a_taken_result_clears,
        (m_tvalid && m_tready && !end_step) |=> !m_tvalid)
    `LESP_ASSERT(a_held_pixel_stays, (a_valid_reg && !a_advance) |=> a_valid_reg)

endmodule

// ===== rtl/lesp_cfg.sv =====
// ----------------------------------------------------------------------------
// lesp_cfg
// Configuration register bank with plain write port.
// ----------------------------------------------------------------------------
module lesp_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lesp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lesp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output lesp_pkg::cfg_t                      cfg
);

    lesp_pkg::cfg_t cfg_reg;
    lesp_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (lesp_pkg::cfg_idx_t'(cfg_index))
                lesp_pkg::CFG_DUTY_UPPER:  cfg_next.duty_upper  = cfg_wdata;
                lesp_pkg::CFG_DUTY_LOWER:  cfg_next.duty_lower  = cfg_wdata;
                lesp_pkg::CFG_LEFT_TOL:
                    cfg_next.left_tol = cfg_wdata[lesp_pkg::EDGE_W-1:0];
                lesp_pkg::CFG_RIGHT_TOL:
                    cfg_next.right_tol = cfg_wdata[lesp_pkg::EDGE_W-1:0];
                lesp_pkg::CFG_GAIN_P:      cfg_next.gain_p      = cfg_wdata;
                lesp_pkg::CFG_GAIN_I:      cfg_next.gain_i      = cfg_wdata;
                lesp_pkg::CFG_GAIN_D:      cfg_next.gain_d      = cfg_wdata;
                lesp_pkg::CFG_CENTRE_DUTY: cfg_next.centre_duty = cfg_wdata;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.duty_upper  <= lesp_pkg::DUTY_UPPER_RST;
            cfg_reg.duty_lower  <= lesp_pkg::DUTY_LOWER_RST;
            cfg_reg.left_tol    <= lesp_pkg::LEFT_TOL_RST;
            cfg_reg.right_tol   <= lesp_pkg::RIGHT_TOL_RST;
            cfg_reg.gain_p      <= lesp_pkg::GAIN_P_RST;
            cfg_reg.gain_i      <= lesp_pkg::GAIN_I_RST;
            cfg_reg.gain_d      <= lesp_pkg::GAIN_D_RST;
            cfg_reg.centre_duty <= lesp_pkg::CENTRE_DUTY_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/lesp_edge.sv =====
// ----------------------------------------------------------------------------
// lesp_edge
// Per-pixel mark tracking and left/right edge extraction at end of line.
// ----------------------------------------------------------------------------
module lesp_edge (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic             pixel,
    input  logic             line_end,
    output lesp_pkg::edges_t edges
);

    lesp_pkg::pos_t  pos_reg;
    logic            first_seen_reg;
    lesp_pkg::idx_t  first_pos_reg;
    lesp_pkg::idx_t  last_pos_reg;
    lesp_pkg::edge_t prior_left_reg;
    lesp_pkg::edge_t prior_right_reg;

    logic            in_line;
    logic            take_first;
    logic            take_last;
    lesp_pkg::idx_t  pos_idx;
    lesp_pkg::pos_t  pos_next;
    logic            first_seen_next;
    lesp_pkg::idx_t  first_pos_next;
    lesp_pkg::idx_t  last_pos_next;
    lesp_pkg::edge_t left_edge;
    lesp_pkg::edge_t right_edge;

    assign in_line    = pos_reg < lesp_pkg::LINE_COUNT;
    assign pos_idx    = pos_reg[lesp_pkg::IDX_W-1:0];
    assign take_first = in_line && pixel && (pos_reg < lesp_pkg::LAST_POS) && !first_seen_reg;
    assign take_last  = in_line && pixel && (pos_reg != '0);

    assign pos_next        = in_line ? pos_reg + 1'b1 : pos_reg;
    assign first_seen_next = first_seen_reg | take_first;
    assign first_pos_next  = take_first ? pos_idx : first_pos_reg;
    assign last_pos_next   = take_last ? pos_idx : last_pos_reg;

    always_comb
    begin
        if (!first_seen_next)
            left_edge = lesp_pkg::edge_t'(lesp_pkg::LAST_IDX);
        else if (first_pos_next == '0)
            left_edge = prior_left_reg;
        else
            left_edge = lesp_pkg::edge_t'(first_pos_next - 1'b1);

        // last position zero means no mark
        if (last_pos_next == '0)
            right_edge = '0;
        else if (last_pos_next == lesp_pkg::LAST_IDX)
            right_edge = prior_right_reg;
        else
            right_edge = lesp_pkg::edge_t'(last_pos_next + 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            first_seen_reg  <= 1'b0;
            first_pos_reg   <= '0;
            last_pos_reg    <= '0;
            prior_left_reg  <= '0;
            prior_right_reg <= '0;
        end
        else if (step)
        begin
            if (line_end)
            begin
                pos_reg         <= '0;
                first_seen_reg  <= 1'b0;
                first_pos_reg   <= '0;
                last_pos_reg    <= '0;
                prior_left_reg  <= left_edge;
                prior_right_reg <= right_edge;
            end
            else
            begin
                pos_reg        <= pos_next;
                first_seen_reg <= first_seen_next;
                first_pos_reg  <= first_pos_next;
                last_pos_reg   <= last_pos_next;
            end
        end
    end

    assign edges.left_edge  = left_edge;
    assign edges.right_edge = right_edge;

endmodule

// ===== rtl/lesp_ctrl.sv =====
// ----------------------------------------------------------------------------
// lesp_ctrl
// Direction decision, incremental PID duty update and speed ramp.
// ----------------------------------------------------------------------------
module lesp_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             end_step,
    input  lesp_pkg::edges_t edges,
    input  lesp_pkg::cfg_t   cfg,
    output lesp_pkg::res_t   res
);

    lesp_pkg::err_t   e1_reg;
    lesp_pkg::err_t   e2_reg;
    lesp_pkg::duty_t  duty_reg;
    lesp_pkg::speed_t speed_reg;

    lesp_pkg::dir_t   dir;
    lesp_pkg::err_t   e0_next;
    lesp_pkg::duty_t  duty_next;
    lesp_pkg::speed_t speed_next;

    logic signed [8:0]  diff1;
    logic signed [9:0]  diff2;
    logic signed [25:0] prod_p;
    logic signed [25:0] prod_i;
    logic signed [26:0] prod_d;
    logic [27:0]        acc;
    logic signed [26:0] half;
    logic signed [26:0] upper_s;
    logic signed [26:0] lower_s;
    lesp_pkg::duty_t    pid_lim;
    lesp_pkg::duty_t    centre_lim;
    lesp_pkg::duty_t    turn_duty;

    logic [12:0]        speed_gap;
    logic [22:0]        ramp;
    lesp_pkg::speed_t   ramp_speed;

    always_comb
    begin
        if (edges.left_edge < cfg.left_tol && edges.right_edge > cfg.right_tol)
            dir = lesp_pkg::DIR_STRAIGHT;
        else if (edges.left_edge >= cfg.left_tol)
            dir = lesp_pkg::DIR_RIGHT;
        else
            dir = lesp_pkg::DIR_LEFT;
    end

    always_comb
    begin
        if (dir == lesp_pkg::DIR_RIGHT)
            e0_next = $signed({1'b0, cfg.left_tol}) - $signed({1'b0, edges.left_edge});
        else
            e0_next = $signed({1'b0, cfg.right_tol}) - $signed({1'b0, edges.right_edge});
    end

    // e0 - e1 and e0 - 2*e1 + e2, sign extended by hand
    assign diff1 = {e0_next[7], e0_next} - {e1_reg[7], e1_reg};
    assign diff2 = {{2{e0_next[7]}}, e0_next} - {e1_reg[7], e1_reg, 1'b0}
                 + {{2{e2_reg[7]}}, e2_reg};

    assign prod_p = $signed({1'b0, cfg.gain_p}) * diff1;
    assign prod_i = $signed({1'b0, cfg.gain_i}) * diff1;
    assign prod_d = $signed({1'b0, cfg.gain_d}) * diff2;

    // accumulate in half units, floor on the way back
    assign acc = {11'b0, duty_reg, 1'b0}
               + {prod_p[25], prod_p, 1'b0}
               + {{2{prod_i[25]}}, prod_i}
               + {prod_d, 1'b0};
    assign half    = acc[27:1];
    assign upper_s = {11'b0, cfg.duty_upper};
    assign lower_s = {11'b0, cfg.duty_lower};

    always_comb
    begin
        if (half > upper_s)
            pid_lim = cfg.duty_upper;
        else if (half < lower_s)
            pid_lim = cfg.duty_lower;
        else
            pid_lim = half[15:0];

        if (cfg.centre_duty > cfg.duty_upper)
            centre_lim = cfg.duty_upper;
        else if (cfg.centre_duty < cfg.duty_lower)
            centre_lim = cfg.duty_lower;
        else
            centre_lim = cfg.centre_duty;

        turn_duty = pid_lim;
        if (dir == lesp_pkg::DIR_RIGHT && pid_lim > cfg.centre_duty)
            turn_duty = cfg.centre_duty;
        if (dir == lesp_pkg::DIR_LEFT && pid_lim < cfg.centre_duty)
            turn_duty = cfg.centre_duty;
    end

    assign speed_gap  = 13'(lesp_pkg::SPEED_TARGET - speed_reg);
    assign ramp       = 23'(speed_gap) * lesp_pkg::SPEED_STEP_GAIN + lesp_pkg::SPEED_ROUND;
    assign ramp_speed = (speed_reg < lesp_pkg::SPEED_TARGET)
                      ? speed_reg + 16'(ramp[22:16]) : speed_reg;

    assign duty_next  = (dir == lesp_pkg::DIR_STRAIGHT) ? centre_lim : turn_duty;
    assign speed_next = (dir == lesp_pkg::DIR_STRAIGHT) ? ramp_speed : lesp_pkg::SPEED_TURN;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_reg    <= '0;
            e2_reg    <= '0;
            duty_reg  <= lesp_pkg::CENTRE_DUTY_RST;
            speed_reg <= lesp_pkg::SPEED_TURN;
        end
        else if (end_step)
        begin
            duty_reg  <= duty_next;
            speed_reg <= speed_next;
            if (dir != lesp_pkg::DIR_STRAIGHT)
            begin
                e1_reg <= e0_next;
                e2_reg <= e1_reg;
            end
        end
    end

    assign res.direction   = dir;
    assign res.servo_duty  = duty_next;
    assign res.drive_speed = speed_next;
    assign res.left_edge   = edges.left_edge;
    assign res.right_edge  = edges.right_edge;
    assign res.steer_error = (dir == lesp_pkg::DIR_STRAIGHT) ? e1_reg : e0_next;

endmodule
